FILE: sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared codes for the sorted key table
// Action and status codes used by the sequencer and the top level.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam logic [2:0] ACT_FIND   = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_ORD    = 3'd2;
    localparam logic [2:0] ACT_UNIQ   = 3'd3;
    localparam logic [2:0] ACT_SORT   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_APPEND   = 2'd3;

    typedef struct packed {
        logic [1:0] rel;
    } skt_cmp_t;

endpackage

FILE: sv/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic single-port RAM
// One access per cycle, registered read data; a write also reads out the old word.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp: shared key comparator
// Compares the request key, or the held key v in sort, with the entry read from the RAM.
// ----------------------------------------------------------------------------
module skt_cmp #(
    parameter int KEY_WIDTH = 32
) (
    input  logic [KEY_WIDTH-1:0] a,
    input  logic [KEY_WIDTH-1:0] b,
    output logic                 eq,
    output logic                 lt
);

    assign eq = (a == b);
    assign lt = (a < b);

endmodule

FILE: sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key table with search, insert and sort
// Keys live in one single-port RAM; a sequencer drives reads, writes and the
// shared comparator one step at a time.
// Throughput: one item at a time; ready is low until the result is taken.
// Reset: count 0, table ordered, no item pending; RAM contents undefined.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // action[2:0], position[9:3], key[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // index[6:0], found[7], status[9:8]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_BREAD, S_BCMP, S_LREAD, S_LCMP,
        S_STORE, S_SHREAD, S_SHWRITE, S_PUT,
        S_SOUTER, S_SREAD, S_SCMP, S_SWR, S_SDONE, S_OUT
    } state_t;

    state_t               state_reg;
    logic [2:0]           act_reg;
    logic [6:0]           pos_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CW-1:0]        count_reg;
    logic                 ord_reg;
    logic signed [CW+1:0] low_reg, high_reg;
    logic [CW-1:0]        probe_reg, ptr_reg, i_reg;
    logic [KEY_WIDTH-1:0] v_reg;
    logic [6:0]           idx_reg;
    logic                 hit_reg;
    logic [1:0]           status_reg;
    logic                 first_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                 c_eq, c_lt;
    logic [KEY_WIDTH-1:0] c_a, c_b;
    skt_cmp_t             cmp;

    skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    skt_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (.a(c_a), .b(c_b), .eq(c_eq), .lt(c_lt));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, status_reg, hit_reg, idx_reg};

    // in sort, compare v (a) against entry (b): entry > v means v < entry
    assign c_a = (state_reg == S_SCMP) ? v_reg : key_reg;
    assign c_b = ram_rdata;
    assign cmp.rel = c_eq ? 2'd0 : (c_lt ? 2'd1 : 2'd2);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = key_reg;
        unique case (state_reg)
            S_BREAD:   ram_addr = probe_reg[AW-1:0];
            S_LREAD:   ram_addr = ptr_reg[AW-1:0];
            S_SHREAD:  ram_addr = AW'(ptr_reg - 1'b1);
            S_SHWRITE:
            begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_PUT:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_reg[AW-1:0];
            end
            S_SOUTER:  ram_addr = i_reg[AW-1:0];
            // keep the lower neighbor on the read port for the shift write
            S_SREAD, S_SCMP: ram_addr = AW'(ptr_reg - 1'b1);
            S_SWR:
            begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg[AW-1:0];
                ram_wdata = first_reg ? v_reg : ram_rdata;
            end
            default:   ram_addr = '0;
        endcase
    end

    logic signed [CW+1:0] nlow, nhigh, span;
    always_comb
    begin
        nlow  = low_reg;
        nhigh = high_reg;
        if (cmp.rel == 2'd1)
        begin
            nhigh = (CW+2)'($signed({2'b00, probe_reg}) - 1);
        end
        else
        begin
            nlow = (CW+2)'($signed({2'b00, probe_reg}) + 1);
        end
        span = nhigh - nlow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ord_reg    <= 1'b1;
            act_reg    <= '0;
            pos_reg    <= '0;
            key_reg    <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            probe_reg  <= '0;
            ptr_reg    <= '0;
            i_reg      <= '0;
            v_reg      <= '0;
            idx_reg    <= '0;
            hit_reg    <= 1'b0;
            status_reg <= ST_OK;
            first_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg    <= s_tdata[2:0];
                        pos_reg    <= s_tdata[9:3];
                        key_reg    <= KEY_WIDTH'(s_tdata[41:10]);
                        hit_reg    <= 1'b0;
                        status_reg <= ST_OK;
                        idx_reg    <= '0;
                        state_reg  <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    low_reg  <= '0;
                    high_reg <= (CW+2)'($signed({2'b00, count_reg}) - 1);
                    ptr_reg  <= '0;
                    if (act_reg == ACT_SORT)
                    begin
                        i_reg     <= CW'(1);
                        state_reg <= S_SOUTER;
                    end
                    else if (act_reg == ACT_FIND || act_reg == ACT_ORD
                             || act_reg == ACT_UNIQ)
                    begin
                        if (act_reg != ACT_FIND && !ord_reg)
                        begin
                            idx_reg    <= 7'(count_reg);
                            status_reg <= ST_APPEND;
                            state_reg  <= S_STORE;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_reg   <= '0;
                            state_reg <= (act_reg == ACT_FIND) ? S_STORE : S_STORE;
                        end
                        else if (ord_reg)
                        begin
                            if (act_reg != ACT_FIND && CW'(pos_reg) < count_reg
                                && 32'(pos_reg) < 32'(count_reg))
                            begin
                                probe_reg <= CW'(pos_reg);
                            end
                            else
                            begin
                                probe_reg <= CW'((count_reg - 1'b1) >> 1);
                            end
                            state_reg <= S_BREAD;
                        end
                        else
                        begin
                            state_reg <= S_LREAD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= pos_reg;
                        state_reg <= S_STORE;
                    end
                end
                S_BREAD:   state_reg <= S_BCMP;
                S_BCMP:
                begin
                    low_reg  <= nlow;
                    high_reg <= nhigh;
                    if (cmp.rel == 2'd0 || span < 0)
                    begin
                        hit_reg   <= (cmp.rel == 2'd0);
                        idx_reg   <= (cmp.rel == 2'd2) ? 7'(probe_reg + 1'b1) : 7'(probe_reg);
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        probe_reg <= CW'(nlow + (span >>> 1));
                        state_reg <= S_BREAD;
                    end
                end
                S_LREAD:   state_reg <= S_LCMP;
                S_LCMP:
                begin
                    if (cmp.rel == 2'd0)
                    begin
                        hit_reg   <= 1'b1;
                        idx_reg   <= 7'(ptr_reg);
                        state_reg <= S_STORE;
                    end
                    else if (ptr_reg + 1'b1 == count_reg)
                    begin
                        idx_reg   <= 7'(count_reg);
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_LREAD;
                    end
                end
                S_STORE:
                begin
                    if (act_reg == ACT_FIND)
                    begin
                        status_reg <= hit_reg ? ST_OK : ST_NOTFOUND;
                        state_reg  <= S_OUT;
                    end
                    else if (act_reg == ACT_UNIQ && hit_reg && status_reg != ST_APPEND)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (count_reg >= CW'(TABLE_DEPTH))
                    begin
                        idx_reg    <= 7'(count_reg);
                        status_reg <= ST_FULL;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        if (act_reg != ACT_ORD && act_reg != ACT_UNIQ)
                        begin
                            ord_reg <= 1'b0;
                        end
                        if (CW'(idx_reg) > count_reg || 32'(idx_reg) > 32'(count_reg))
                        begin
                            idx_reg <= 7'(count_reg);
                        end
                        ptr_reg   <= count_reg;
                        state_reg <= S_SHREAD;
                    end
                end
                S_SHREAD:
                begin
                    if (32'(ptr_reg) > 32'(idx_reg))
                    begin
                        state_reg <= S_SHWRITE;
                    end
                    else
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_SHWRITE:
                begin
                    ptr_reg   <= ptr_reg - 1'b1;
                    state_reg <= S_SHREAD;
                end
                S_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_SOUTER:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= S_SDONE;
                    end
                    else
                    begin
                        ptr_reg   <= i_reg;
                        state_reg <= S_SREAD;
                        first_reg <= 1'b0;
                    end
                end
                S_SREAD:
                begin
                    if (!first_reg && ptr_reg == i_reg)
                    begin
                        v_reg <= ram_rdata;
                    end
                    if (ptr_reg == '0)
                    begin
                        first_reg <= 1'b1;
                        state_reg <= S_SWR;
                    end
                    else
                    begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP:
                begin
                    if (cmp.rel == 2'd1)
                    begin
                        first_reg <= 1'b0;
                    end
                    else
                    begin
                        first_reg <= 1'b1;
                    end
                    state_reg <= S_SWR;
                end
                S_SWR:
                begin
                    if (first_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SOUTER;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        state_reg <= S_SREAD;
                    end
                end
                S_SDONE:
                begin
                    ord_reg   <= 1'b1;
                    idx_reg   <= 7'(count_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
